[hdl/bps_pkg.sv]
// Shared types, widths and constants of the Blinn-Phong fragment shader.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CAMERA_Z = 3'd5;

   // Field widths
   localparam int POS_W  = 32;   // Q16.16 positions
   localparam int DIFF_W = 33;   // exact position difference
   localparam int NRM_W  = 16;   // Q1.14 vectors
   localparam int TEX_W  = 8;
   localparam int FRAC   = 14;

   // Normalizer internals
   localparam int MAG_W      = 24;               // scaled magnitude, top bit at 23
   localparam int LZ_W       = 6;                // bit position of a DIFF_W word
   localparam int SQ_W       = 2 * MAG_W;
   localparam int SUM_W      = 50;               // three squares, even width
   localparam int ROOT_W     = SUM_W / 2;
   localparam int REM_W      = ROOT_W + 3;
   localparam int QUO_W      = FRAC + 1;         // quotient up to 1.0
   localparam int DREM_W     = ROOT_W + 1;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = QUO_W;
   localparam int NORM_LAT   = 4 + SQRT_STEPS + 1 + DIV_STEPS + 1;

   // Dot product and color path
   localparam int DOT_LAT  = 2;
   localparam int DOT_W    = 20;
   localparam int SPEC_W   = 17;
   localparam int S2_W     = 20;
   localparam int S3_W     = 23;
   localparam int S6_W     = 32;
   localparam int FACT_W   = 33;
   localparam int PROD_W   = 41;
   localparam int COLOR_LAT = 6;
   localparam int TOTAL_LAT = 1 + NORM_LAT + 1 + NORM_LAT + DOT_LAT + COLOR_LAT;

   localparam logic signed [DOT_W-1:0] LAMBERT_FLOOR = 20'sd3277;   // 0.2 in Q.14
   localparam logic signed [NRM_W-1:0] ONE_Q14       = 16'sd16384;
   localparam logic [PROD_W:0]         AMBIENT_Q14   = (PROD_W+1)'(10) << FRAC;
   localparam logic [TEX_W-1:0]        CHANNEL_MAX   = 8'd255;

   typedef logic [2:0][DIFF_W-1:0] dvec_type;   // signed components
   typedef logic [2:0][NRM_W-1:0]  uvec_type;   // signed Q1.14 components

   typedef struct packed {
      logic [TEX_W-1:0]        texel_red;
      logic [TEX_W-1:0]        texel_green;
      logic [TEX_W-1:0]        texel_blue;
      logic signed [POS_W-1:0] world_x;
      logic signed [POS_W-1:0] world_y;
      logic signed [POS_W-1:0] world_z;
      logic signed [NRM_W-1:0] normal_x;
      logic signed [NRM_W-1:0] normal_y;
      logic signed [NRM_W-1:0] normal_z;
   } frag_type;

   typedef struct packed {
      logic [TEX_W-1:0] shaded_red;
      logic [TEX_W-1:0] shaded_green;
      logic [TEX_W-1:0] shaded_blue;
   } color_type;

   typedef struct packed {
      logic [TEX_W-1:0] red;
      logic [TEX_W-1:0] green;
      logic [TEX_W-1:0] blue;
   } texel_type;

   // Per-fragment data that rides beside the vector math
   typedef struct packed {
      texel_type texel;
      uvec_type  normal;
   } side_type;

endpackage

`default_nettype wire

[hdl/bps_norm.sv]
// Pipelined 3-vector normalizer: scale, sum of squares, bit-serial square root
// and restoring division, one stage per root or quotient bit. Uses bps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bps_norm import bps_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  dvec_type in_vec,
   output logic     out_valid,
   output uvec_type out_vec
);

   localparam logic [LZ_W-1:0] TOP_POS = LZ_W'(MAG_W - 1);

   // Stage 1: magnitudes and largest magnitude
   logic [2:0][DIFF_W-1:0] mag1_in, mag1_ff;
   logic [DIFF_W-1:0]      max1_in, max1_ff;
   logic [2:0]             neg1_in, neg1_ff;
   logic                   v1_ff;

   always_comb begin
      max1_in = '0;
      for (int i = 0; i < 3; i++) begin
         neg1_in[i] = in_vec[i][DIFF_W-1];
         mag1_in[i] = neg1_in[i] ? DIFF_W'(-in_vec[i]) : in_vec[i];
         if (mag1_in[i] > max1_in) max1_in = mag1_in[i];
      end
   end

   // Stage 2: leading one of the largest magnitude
   logic [LZ_W-1:0]        pos2_in, pos2_ff;
   logic [2:0][DIFF_W-1:0] mag2_ff;
   logic [2:0]             neg2_ff;
   logic                   zero2_ff, v2_ff;

   always_comb begin
      pos2_in = '0;
      for (int i = 0; i < DIFF_W; i++) begin
         if (max1_ff[i]) pos2_in = LZ_W'(i);
      end
   end

   // Stage 3: shift so that the largest magnitude has its top bit at 23
   logic [2:0][MAG_W-1:0] mag3_in, mag3_ff;
   logic [2:0]            neg3_ff;
   logic                  zero3_ff, v3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (pos2_ff >= TOP_POS) begin
            mag3_in[i] = MAG_W'(mag2_ff[i] >> (pos2_ff - TOP_POS));
         end else begin
            mag3_in[i] = MAG_W'(mag2_ff[i] << (TOP_POS - pos2_ff));
         end
      end
   end

   // Stage 4: squares
   logic [2:0][SQ_W-1:0]  sq4_ff;
   logic [2:0][MAG_W-1:0] mag4_ff;
   logic [2:0]            neg4_ff;
   logic                  zero4_ff, v4_ff;

   // Square root pipeline; entry 0 holds the sum of squares
   logic                  sq_valid_ff [0:SQRT_STEPS];
   logic [SUM_W-1:0]      sq_sum_ff   [0:SQRT_STEPS];
   logic [ROOT_W-1:0]     sq_root_ff  [0:SQRT_STEPS];
   logic [REM_W-1:0]      sq_rem_ff   [0:SQRT_STEPS];
   logic [2:0][MAG_W-1:0] sq_mag_ff   [0:SQRT_STEPS];
   logic [2:0]            sq_neg_ff   [0:SQRT_STEPS];
   logic                  sq_zero_ff  [0:SQRT_STEPS];
   logic [ROOT_W-1:0]     sq_root_in  [1:SQRT_STEPS];
   logic [REM_W-1:0]      sq_rem_in   [1:SQRT_STEPS];

   // One root bit per stage: bring down two bits, try 4*root+1
   always_comb begin
      logic [1:0]       pair;
      logic [REM_W-1:0] trial_rem;
      logic [REM_W-1:0] trial;
      for (int k = 1; k <= SQRT_STEPS; k++) begin
         pair      = 2'(sq_sum_ff[k-1] >> (SUM_W - 2 * k));
         trial_rem = {sq_rem_ff[k-1][REM_W-3:0], pair};
         trial     = {1'b0, sq_root_ff[k-1], 2'b01};
         if (trial_rem >= trial) begin
            sq_rem_in[k]  = trial_rem - trial;
            sq_root_in[k] = {sq_root_ff[k-1][ROOT_W-2:0], 1'b1};
         end else begin
            sq_rem_in[k]  = trial_rem;
            sq_root_in[k] = {sq_root_ff[k-1][ROOT_W-2:0], 1'b0};
         end
      end
   end

   // Division pipeline: one quotient bit of mag * 2^14 / len per stage
   logic                   dv_valid_ff [0:DIV_STEPS-1];
   logic [ROOT_W-1:0]      dv_len_ff   [0:DIV_STEPS-1];
   logic [2:0][DREM_W-1:0] dv_rem_ff   [0:DIV_STEPS-1];
   logic [2:0][QUO_W-1:0]  dv_q_ff     [0:DIV_STEPS-1];
   logic [2:0]             dv_neg_ff   [0:DIV_STEPS-1];
   logic                   dv_zero_ff  [0:DIV_STEPS-1];
   logic [2:0][DREM_W-1:0] dv_rem_in   [0:DIV_STEPS-1];
   logic [2:0][QUO_W-1:0]  dv_q_in     [0:DIV_STEPS-1];

   // Inputs of each division stage: the root stage feeds stage 0
   logic [ROOT_W-1:0]      dv_len_src  [0:DIV_STEPS-1];
   logic [2:0][DREM_W-1:0] dv_rem_src  [0:DIV_STEPS-1];
   logic [2:0][QUO_W-1:0]  dv_q_src    [0:DIV_STEPS-1];
   logic [2:0]             dv_neg_src  [0:DIV_STEPS-1];
   logic                   dv_zero_src [0:DIV_STEPS-1];

   always_comb begin
      dv_len_src[0]  = sq_root_ff[SQRT_STEPS];
      dv_q_src[0]    = '0;
      dv_neg_src[0]  = sq_neg_ff[SQRT_STEPS];
      dv_zero_src[0] = sq_zero_ff[SQRT_STEPS];
      for (int i = 0; i < 3; i++) begin
         dv_rem_src[0][i] = DREM_W'(sq_mag_ff[SQRT_STEPS][i]);
      end
      for (int k = 1; k < DIV_STEPS; k++) begin
         dv_len_src[k]  = dv_len_ff[k-1];
         dv_rem_src[k]  = dv_rem_ff[k-1];
         dv_q_src[k]    = dv_q_ff[k-1];
         dv_neg_src[k]  = dv_neg_ff[k-1];
         dv_zero_src[k] = dv_zero_ff[k-1];
      end
   end

   always_comb begin
      logic [ROOT_W-1:0] len_c;
      logic [DREM_W-1:0] rem_c;
      logic [DREM_W-1:0] rem_s;
      logic [QUO_W-1:0]  q_c;
      logic              ge;
      for (int k = 0; k < DIV_STEPS; k++) begin
         len_c = dv_len_src[k];
         for (int i = 0; i < 3; i++) begin
            rem_c = dv_rem_src[k][i];
            q_c   = dv_q_src[k][i];
            ge    = rem_c >= DREM_W'(len_c);
            rem_s = ge ? rem_c - DREM_W'(len_c) : rem_c;
            dv_rem_in[k][i] = {rem_s[DREM_W-2:0], 1'b0};
            dv_q_in[k][i]   = {q_c[QUO_W-2:0], ge};
         end
      end
   end

   // Final stage: restore signs
   uvec_type out_in, out_ff;
   logic     out_valid_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dv_zero_ff[DIV_STEPS-1]) begin
            out_in[i] = '0;
         end else if (dv_neg_ff[DIV_STEPS-1][i]) begin
            out_in[i] = NRM_W'(-{1'b0, dv_q_ff[DIV_STEPS-1][i]});
         end else begin
            out_in[i] = NRM_W'(dv_q_ff[DIV_STEPS-1][i]);
         end
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k <= SQRT_STEPS; k++) sq_valid_ff[k] <= 1'b0;
         for (int k = 0; k < DIV_STEPS; k++) dv_valid_ff[k] <= 1'b0;
      end else begin
         v1_ff          <= in_valid;
         v2_ff          <= v1_ff;
         v3_ff          <= v2_ff;
         v4_ff          <= v3_ff;
         sq_valid_ff[0] <= v4_ff;
         for (int k = 1; k <= SQRT_STEPS; k++) sq_valid_ff[k] <= sq_valid_ff[k-1];
         dv_valid_ff[0] <= sq_valid_ff[SQRT_STEPS];
         for (int k = 1; k < DIV_STEPS; k++) dv_valid_ff[k] <= dv_valid_ff[k-1];
         out_valid_ff   <= dv_valid_ff[DIV_STEPS-1];
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      mag1_ff  <= mag1_in;
      max1_ff  <= max1_in;
      neg1_ff  <= neg1_in;

      pos2_ff  <= pos2_in;
      mag2_ff  <= mag1_ff;
      neg2_ff  <= neg1_ff;
      zero2_ff <= (max1_ff == '0);

      mag3_ff  <= mag3_in;
      neg3_ff  <= neg2_ff;
      zero3_ff <= zero2_ff;

      for (int i = 0; i < 3; i++) sq4_ff[i] <= SQ_W'(mag3_ff[i]) * SQ_W'(mag3_ff[i]);
      mag4_ff  <= mag3_ff;
      neg4_ff  <= neg3_ff;
      zero4_ff <= zero3_ff;

      sq_sum_ff[0]  <= SUM_W'(sq4_ff[0]) + SUM_W'(sq4_ff[1]) + SUM_W'(sq4_ff[2]);
      sq_root_ff[0] <= '0;
      sq_rem_ff[0]  <= '0;
      sq_mag_ff[0]  <= mag4_ff;
      sq_neg_ff[0]  <= neg4_ff;
      sq_zero_ff[0] <= zero4_ff;
      for (int k = 1; k <= SQRT_STEPS; k++) begin
         sq_sum_ff[k]  <= sq_sum_ff[k-1];
         sq_root_ff[k] <= sq_root_in[k];
         sq_rem_ff[k]  <= sq_rem_in[k];
         sq_mag_ff[k]  <= sq_mag_ff[k-1];
         sq_neg_ff[k]  <= sq_neg_ff[k-1];
         sq_zero_ff[k] <= sq_zero_ff[k-1];
      end

      for (int k = 0; k < DIV_STEPS; k++) begin
         dv_rem_ff[k]  <= dv_rem_in[k];
         dv_q_ff[k]    <= dv_q_in[k];
         dv_len_ff[k]  <= dv_len_src[k];
         dv_neg_ff[k]  <= dv_neg_src[k];
         dv_zero_ff[k] <= dv_zero_src[k];
      end

      out_ff <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_vec   = out_ff;

   // Every result matches a vector that entered the normalizer
   a_latency: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> $past(in_valid, NORM_LAT))
      else $error("normalizer result without matching input");

   // The root is the floor square root of the sum of squares
   a_root: assert property (@(posedge clock) disable iff (reset)
      sq_valid_ff[SQRT_STEPS] |->
         ((52'(sq_root_ff[SQRT_STEPS]) * 52'(sq_root_ff[SQRT_STEPS]) <=
           52'(sq_sum_ff[SQRT_STEPS])) &&
          ((52'(sq_root_ff[SQRT_STEPS]) + 52'd1) * (52'(sq_root_ff[SQRT_STEPS]) + 52'd1) >
           52'(sq_sum_ff[SQRT_STEPS]))))
      else $error("square root out of range");

   // Unit components never exceed one
   a_unit: assert property (@(posedge clock) disable iff (reset)
      out_valid |->
         ($signed(out_vec[0]) <= ONE_Q14 && $signed(out_vec[0]) >= -ONE_Q14 &&
          $signed(out_vec[1]) <= ONE_Q14 && $signed(out_vec[1]) >= -ONE_Q14 &&
          $signed(out_vec[2]) <= ONE_Q14 && $signed(out_vec[2]) >= -ONE_Q14))
      else $error("unit vector component above one");

endmodule

`default_nettype wire

[hdl/bps_dot.sv]
// Two-stage Q1.14 dot product with floor to Q.14.
// Uses bps_pkg for vector types and widths.
`timescale 1ns / 1ps
`default_nettype none

module bps_dot import bps_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  uvec_type                in_a,
   input  uvec_type                in_b,
   output logic                    out_valid,
   output logic signed [DOT_W-1:0] out_dot
);

   logic signed [2*NRM_W-1:0] prod_ff [3];
   logic signed [2*NRM_W+1:0] sum_c;
   logic signed [DOT_W-1:0]   dot_ff;
   logic                      v1_ff, v2_ff;

   // Sum of products, arithmetic shift is the floor
   assign sum_c = (2*NRM_W+2)'(prod_ff[0]) + (2*NRM_W+2)'(prod_ff[1]) +
                  (2*NRM_W+2)'(prod_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) prod_ff[i] <= $signed(in_a[i]) * $signed(in_b[i]);
      dot_ff <= DOT_W'(sum_c >>> FRAC);
   end

   assign out_valid = v2_ff;
   assign out_dot   = dot_ff;

endmodule

`default_nettype wire

[hdl/bps_color.sv]
// Specular power six, lighting factor and per-channel shading with saturation.
// Six register stages; uses bps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bps_color import bps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [SPEC_W-1:0] in_spec,
   input  logic [SPEC_W-1:0] in_lam,
   input  texel_type         in_texel,
   output logic              out_valid,
   output color_type         out_color
);

   logic [COLOR_LAT-1:0] v_ff;

   logic [S2_W-1:0]   s2_ff;
   logic [S3_W-1:0]   s3_ff;
   logic [S6_W-1:0]   s6_ff;
   logic [FACT_W-1:0] fact_ff;
   logic [SPEC_W-1:0] spec1_ff;
   logic [SPEC_W-1:0] lam1_ff, lam2_ff, lam3_ff;
   texel_type         tex1_ff, tex2_ff, tex3_ff, tex4_ff;
   logic [2:0][PROD_W-1:0] prod_ff;
   color_type         color_ff;

   logic [2*SPEC_W-1:0]    p2_c;
   logic [S2_W+SPEC_W-1:0] p3_c;
   logic [2*S3_W-1:0]      p6_c;
   logic [2:0][TEX_W-1:0]  tex_c;
   color_type              color_in;

   assign p2_c  = (2*SPEC_W)'(in_spec) * (2*SPEC_W)'(in_spec);
   assign p3_c  = (S2_W+SPEC_W)'(s2_ff) * (S2_W+SPEC_W)'(spec1_ff);
   assign p6_c  = (2*S3_W)'(s3_ff) * (2*S3_W)'(s3_ff);
   assign tex_c = {tex4_ff.red, tex4_ff.green, tex4_ff.blue};

   // Add ambient, drop the fraction, saturate
   always_comb begin
      logic [PROD_W:0]        ch;
      logic [PROD_W-FRAC:0]   whole;
      logic [2:0][TEX_W-1:0]  sat;
      for (int i = 0; i < 3; i++) begin
         ch     = (PROD_W+1)'(prod_ff[i]) + AMBIENT_Q14;
         whole  = (PROD_W-FRAC+1)'(ch >> FRAC);
         sat[i] = (whole > (PROD_W-FRAC+1)'(CHANNEL_MAX)) ? CHANNEL_MAX : whole[TEX_W-1:0];
      end
      color_in.shaded_red   = sat[2];
      color_in.shaded_green = sat[1];
      color_in.shaded_blue  = sat[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[COLOR_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      // s^2
      s2_ff    <= S2_W'(p2_c >> FRAC);
      spec1_ff <= in_spec;
      lam1_ff  <= in_lam;
      tex1_ff  <= in_texel;
      // s^3
      s3_ff    <= S3_W'(p3_c >> FRAC);
      lam2_ff  <= lam1_ff;
      tex2_ff  <= tex1_ff;
      // s^6
      s6_ff    <= S6_W'(p6_c >> FRAC);
      lam3_ff  <= lam2_ff;
      tex3_ff  <= tex2_ff;
      // diffuse plus specular
      fact_ff  <= FACT_W'(lam3_ff) + FACT_W'(s6_ff);
      tex4_ff  <= tex3_ff;
      // texel times factor
      for (int i = 0; i < 3; i++) prod_ff[i] <= PROD_W'(tex_c[i]) * PROD_W'(fact_ff);
      color_ff <= color_in;
   end

   assign out_valid = v_ff[COLOR_LAT-1];
   assign out_color = color_ff;

endmodule

`default_nettype wire

[hdl/blinn_phong_fragment_shade_top.sv]
// Blinn-Phong fragment shader top level: CSRs, vector setup and pipeline glue.
// Uses bps_pkg, bps_norm, bps_dot and bps_color.
//
// Usage:
//   Fragments enter on req_data; a transfer happens at each clock edge with
//   start high and busy low. busy is low except during reset, so one fragment
//   may enter every cycle.
//   Each shaded color appears on rsp_data for one cycle with rsp_valid high.
//   Results come out in input order, one per fragment, at one per cycle
//   sustained. The latency is set by two normalizers in series (light and
//   half vector), each 46 stages: one stage per square-root bit and per
//   quotient bit. The receiver cannot hold results off; none is needed, as
//   the pipeline never stalls.
//   Light and camera positions go in through csr_we / csr_index / csr_data;
//   the user must write them only while no fragment is in flight, as the
//   block does not enforce it. Indexes above 5 are ignored. Synchronous
//   reset clears the positions to zero and drops every fragment in flight.
`timescale 1ns / 1ps
`default_nettype none

module blinn_phong_fragment_shade_top import bps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  frag_type              req_data,
   output logic                  rsp_valid,
   output color_type             rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int SIDE_DLY = 1 + NORM_LAT;
   localparam int LAM_DLY  = 1 + NORM_LAT - DOT_LAT;

   // Configuration registers
   logic signed [POS_W-1:0] light_ff  [3];
   logic signed [POS_W-1:0] camera_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            light_ff[i]  <= '0;
            camera_ff[i] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LIGHT_X:  light_ff[0]  <= csr_data;
            CSR_LIGHT_Y:  light_ff[1]  <= csr_data;
            CSR_LIGHT_Z:  light_ff[2]  <= csr_data;
            CSR_CAMERA_X: camera_ff[0] <= csr_data;
            CSR_CAMERA_Y: camera_ff[1] <= csr_data;
            CSR_CAMERA_Z: camera_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   assign busy = reset;

   // Input stage: position differences
   logic signed [POS_W-1:0] world_c [3];
   dvec_type dl_in, dl_ff, de_in, de_ff;
   side_type side0_in, side0_ff;
   logic     t0_valid_ff;

   assign world_c = '{req_data.world_x, req_data.world_y, req_data.world_z};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dl_in[i] = DIFF_W'(light_ff[i]) - DIFF_W'(world_c[i]);
         de_in[i] = DIFF_W'(camera_ff[i]) - DIFF_W'(world_c[i]);
      end
      side0_in.texel.red   = req_data.texel_red;
      side0_in.texel.green = req_data.texel_green;
      side0_in.texel.blue  = req_data.texel_blue;
      side0_in.normal      = {req_data.normal_z, req_data.normal_y, req_data.normal_x};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t0_valid_ff <= 1'b0;
      end else begin
         t0_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      dl_ff    <= dl_in;
      de_ff    <= de_in;
      side0_ff <= side0_in;
   end

   // Light and eye normalizers
   logic     l_valid, e_valid;
   uvec_type l_vec, e_vec;

   bps_norm u_norm_light (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (t0_valid_ff),
      .in_vec    (dl_ff),
      .out_valid (l_valid),
      .out_vec   (l_vec)
   );

   bps_norm u_norm_eye (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (t0_valid_ff),
      .in_vec    (de_ff),
      .out_valid (e_valid),
      .out_vec   (e_vec)
   );

   // Side data follows the light normalizer
   side_type side1_ff [NORM_LAT];

   always_ff @(posedge clock) begin
      side1_ff[0] <= side0_ff;
      for (int k = 1; k < NORM_LAT; k++) side1_ff[k] <= side1_ff[k-1];
   end

   // Half vector sum
   dvec_type hs_ff;
   logic     hs_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hs_valid_ff <= 1'b0;
      end else begin
         hs_valid_ff <= l_valid;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         hs_ff[i] <= DIFF_W'($signed(l_vec[i])) + DIFF_W'($signed(e_vec[i]));
      end
   end

   logic     h_valid;
   uvec_type h_vec;

   bps_norm u_norm_half (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hs_valid_ff),
      .in_vec    (hs_ff),
      .out_valid (h_valid),
      .out_vec   (h_vec)
   );

   // Diffuse term from L and N, floored at 0.2
   logic                    lam_valid;
   logic signed [DOT_W-1:0] lam_dot;
   logic [SPEC_W-1:0]       lam_c;

   bps_dot u_dot_diffuse (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (l_valid),
      .in_a      (l_vec),
      .in_b      (side1_ff[NORM_LAT-1].normal),
      .out_valid (lam_valid),
      .out_dot   (lam_dot)
   );

   assign lam_c = (lam_dot < LAMBERT_FLOOR) ? SPEC_W'(LAMBERT_FLOOR) : lam_dot[SPEC_W-1:0];

   // Align diffuse term and side data with the half vector
   logic [SPEC_W-1:0] lam_d_ff  [LAM_DLY];
   side_type          side2_ff  [SIDE_DLY];

   always_ff @(posedge clock) begin
      lam_d_ff[0] <= lam_c;
      for (int k = 1; k < LAM_DLY; k++) lam_d_ff[k] <= lam_d_ff[k-1];
      side2_ff[0] <= side1_ff[NORM_LAT-1];
      for (int k = 1; k < SIDE_DLY; k++) side2_ff[k] <= side2_ff[k-1];
   end

   // Specular dot product
   logic                    spec_valid;
   logic signed [DOT_W-1:0] spec_dot;
   logic [SPEC_W-1:0]       spec_c;

   bps_dot u_dot_spec (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (h_valid),
      .in_a      (h_vec),
      .in_b      (side2_ff[SIDE_DLY-1].normal),
      .out_valid (spec_valid),
      .out_dot   (spec_dot)
   );

   assign spec_c = spec_dot[DOT_W-1] ? '0 : spec_dot[SPEC_W-1:0];

   logic [SPEC_W-1:0] lam3_ff [DOT_LAT];
   texel_type         tex3_ff [DOT_LAT];

   always_ff @(posedge clock) begin
      lam3_ff[0] <= lam_d_ff[LAM_DLY-1];
      tex3_ff[0] <= side2_ff[SIDE_DLY-1].texel;
      for (int k = 1; k < DOT_LAT; k++) begin
         lam3_ff[k] <= lam3_ff[k-1];
         tex3_ff[k] <= tex3_ff[k-1];
      end
   end

   // Power, factor and channel shading
   bps_color u_color (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (spec_valid),
      .in_spec   (spec_c),
      .in_lam    (lam3_ff[DOT_LAT-1]),
      .in_texel  (tex3_ff[DOT_LAT-1]),
      .out_valid (rsp_valid),
      .out_color (rsp_data)
   );

   // Every result belongs to an earlier input transfer
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, TOTAL_LAT))
      else $error("result without matching input transfer");

   // Light and eye normalizers run in lockstep
   a_lockstep: assert property (@(posedge clock) disable iff (reset)
      l_valid == e_valid)
      else $error("light and eye normalizers out of step");

   // Diffuse term trails the light vector through the dot product
   a_diffuse_step: assert property (@(posedge clock) disable iff (reset)
      lam_valid == $past(l_valid, DOT_LAT))
      else $error("diffuse term out of step with light vector");

endmodule

`default_nettype wire
